FILE: hdl/sild_pkg.sv
// shared types and constants for the sender-initiated load dispatcher
package sild_pkg;

  localparam int TIME_W     = 32;
  localparam int TAG_W      = 16;
  localparam int BURST_W    = 16;
  localparam int PROC_W     = 3;
  localparam int THR_W      = 20;
  localparam int NUM_THR    = 8;
  localparam int THR_IDX_W  = 3;
  localparam int ACC_W      = 34;
  localparam int ENTRY_W    = TIME_W + BURST_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

  localparam logic STATUS_QUEUED   = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP_SEL,
    S_DROP_CHK,
    S_LOAD_INIT,
    S_LOAD_RD,
    S_LOAD_ACC,
    S_POLL_SEL,
    S_POLL_HEAD,
    S_POLL_SUB,
    S_POLL_RD,
    S_POLL_ACC,
    S_PLACE,
    S_COMMIT
  } sild_state_t;

endpackage

FILE: hdl/sender_initiated_load_dispatcher.sv
// top level of the sender-initiated load dispatcher: sequencer, job store, shared adder
// One job is handled at a time and in_stall stays high until its result is loaded into
// the output register. The drop scan visits each processor in turn and drops from the
// head of its queue every job that ended before the arrival time. The load of the
// preferred processor is then summed over its queue. When polling, the other processors
// are visited in turn: an idle one is taken, a busy one has its remaining load summed,
// and the preferred processor is used when none qualifies. Placing follows, then the
// return to idle, which waits while a result is stalled. The time a job takes is set
// by the single read port of the job store, whose read data are registered, and by the
// one adder and one comparator that the steps share. The job store needs no clearing
// pass after reset.
module sender_initiated_load_dispatcher #(
  parameter int NUM_PROC    = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sild_pkg::TAG_W-1:0]    in_job_tag,
  input  logic [sild_pkg::TIME_W-1:0]   in_arrival_time,
  input  logic [sild_pkg::BURST_W-1:0]  in_burst_time,
  input  logic [sild_pkg::PROC_W-1:0]   in_preferred_processor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sild_pkg::TAG_W-1:0]    out_result_tag,
  output logic [sild_pkg::PROC_W-1:0]   out_assigned_processor,
  output logic [sild_pkg::TIME_W-1:0]   out_start_time,
  output logic [sild_pkg::TIME_W-1:0]   out_end_time,
  output logic                          out_redirected,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sild_pkg::THR_IDX_W-1:0] cfg_index,
  input  logic [sild_pkg::THR_W-1:0]    cfg_data
);
  import sild_pkg::*;

  localparam int PW  = $clog2(NUM_PROC);
  localparam int PCW = $clog2(NUM_PROC + 1);
  localparam int HW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = CW + 1;
  localparam int AW  = $clog2(NUM_PROC * QUEUE_DEPTH);
  localparam int MEM_DEPTH = NUM_PROC * QUEUE_DEPTH;

  function automatic logic [PW-1:0] pref_reduce(input logic [PROC_W-1:0] v);
    logic [PROC_W:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 4; i++) begin
      if (t >= (PROC_W+1)'(NUM_PROC)) t = t - (PROC_W+1)'(NUM_PROC);
    end
    return PW'(t);
  endfunction

  sild_state_t state_r, state_nxt;

  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [TIME_W-1:0]  arr_r, arr_nxt;
  logic [BURST_W-1:0] burst_r, burst_nxt;
  logic [PW-1:0]      pref_r, pref_nxt;
  logic [PCW-1:0]     proc_r, proc_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]      kcnt_r, kcnt_nxt;
  logic [HW-1:0]      slot_r, slot_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic               status_r, status_nxt;

  logic [HW-1:0]      head_r [NUM_PROC];
  logic [HW-1:0]      head_nxt [NUM_PROC];
  logic [CW-1:0]      count_r [NUM_PROC];
  logic [CW-1:0]      count_nxt [NUM_PROC];
  logic [TIME_W-1:0]  last_r [NUM_PROC];
  logic [TIME_W-1:0]  last_nxt [NUM_PROC];
  logic [THR_W-1:0]   thr_r [NUM_THR];

  logic               res_valid_r, res_valid_nxt;
  logic [TAG_W-1:0]   res_tag_r, res_tag_nxt;
  logic [PROC_W-1:0]  res_proc_r, res_proc_nxt;
  logic [TIME_W-1:0]  res_start_r, res_start_nxt;
  logic [TIME_W-1:0]  res_end_r, res_end_nxt;
  logic               res_redir_r, res_redir_nxt;
  logic               res_status_r, res_status_nxt;

  logic [ENTRY_W-1:0] job_mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] mem_q;
  logic [AW-1:0]      mem_raddr;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_we;

  logic [PW-1:0]      pidx;
  logic [THR_IDX_W-1:0] thr_idx;
  logic [HW-1:0]      cur_head;
  logic [CW-1:0]      cur_cnt;
  logic [TIME_W-1:0]  cur_last;
  logic [THR_W-1:0]   cur_thr;
  logic               proc_end;
  logic [TIME_W-1:0]  mem_start;
  logic [BURST_W-1:0] mem_burst;
  logic [AW-1:0]      proc_base;
  logic [TW-1:0]      tail_sum;
  logic [HW-1:0]      tail_slot;
  logic [HW-1:0]      head_inc;
  logic [HW-1:0]      slot_inc;
  logic               out_free;
  logic               in_fire;

  logic [ACC_W-1:0]   add_a, add_b, add_s;
  logic               add_ci;
  logic [TIME_W-1:0]  sum_sat;
  logic [ACC_W-1:0]   cmp_a, cmp_b;
  logic               cmp_lt;

  assign pidx      = proc_r[PW-1:0];
  assign thr_idx   = THR_IDX_W'(pidx);
  assign cur_head  = head_r[pidx];
  assign cur_cnt   = count_r[pidx];
  assign cur_last  = last_r[pidx];
  assign cur_thr   = thr_r[thr_idx];
  assign proc_end  = (proc_r == PCW'(NUM_PROC));
  assign mem_start = mem_q[TIME_W-1:0];
  assign mem_burst = mem_q[ENTRY_W-1:TIME_W];
  assign proc_base = AW'(AW'(pidx) * AW'(QUEUE_DEPTH));
  assign tail_sum  = TW'(cur_head) + TW'(cur_cnt);
  assign tail_slot = (tail_sum >= TW'(QUEUE_DEPTH)) ? HW'(tail_sum - TW'(QUEUE_DEPTH))
                                                    : HW'(tail_sum);
  assign head_inc  = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign slot_inc  = (slot_r == HW'(QUEUE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign out_free  = !res_valid_r || !out_stall;
  assign in_fire   = in_valid && !in_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid              = res_valid_r;
  assign out_result_tag         = res_tag_r;
  assign out_assigned_processor = res_proc_r;
  assign out_start_time         = res_start_r;
  assign out_end_time           = res_end_r;
  assign out_redirected         = res_redir_r;
  assign out_status             = res_status_r;

  // shared adder operands
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (state_r)
      S_DROP_CHK, S_POLL_HEAD: begin
        add_a = ACC_W'(mem_start);
        add_b = ACC_W'(mem_burst);
      end
      S_LOAD_ACC, S_POLL_ACC: begin
        add_a = acc_r;
        add_b = ACC_W'(mem_burst);
      end
      S_POLL_SUB: begin
        add_a  = acc_r;
        add_b  = ~ACC_W'(arr_r);
        add_ci = 1'b1;
      end
      S_COMMIT: begin
        add_a = ACC_W'(start_r);
        add_b = ACC_W'(burst_r);
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_s   = add_a + add_b + ACC_W'(add_ci);
  assign sum_sat = (|add_s[ACC_W-1:TIME_W]) ? '1 : add_s[TIME_W-1:0];

  // shared comparator operands
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      S_DROP_CHK: begin
        cmp_a = ACC_W'(sum_sat);
        cmp_b = ACC_W'(arr_r);
      end
      S_LOAD_RD, S_POLL_RD: begin
        cmp_a = acc_r;
        cmp_b = ACC_W'(cur_thr);
      end
      S_POLL_SUB: begin
        cmp_a = acc_r;
        cmp_b = ACC_W'(arr_r);
      end
      S_PLACE: begin
        cmp_a = ACC_W'(arr_r);
        cmp_b = ACC_W'(cur_last);
      end
      default: begin
        cmp_a = '0;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DROP_SEL;
      end
      S_DROP_SEL: begin
        if (proc_end) state_nxt = S_LOAD_INIT;
        else if (cur_cnt != '0) state_nxt = S_DROP_CHK;
      end
      S_DROP_CHK:  state_nxt = S_DROP_SEL;
      S_LOAD_INIT: state_nxt = S_LOAD_RD;
      S_LOAD_RD: begin
        if (kcnt_r != cur_cnt) state_nxt = S_LOAD_ACC;
        else if (cmp_lt) state_nxt = S_PLACE;
        else state_nxt = S_POLL_SEL;
      end
      S_LOAD_ACC:  state_nxt = S_LOAD_RD;
      S_POLL_SEL: begin
        if (proc_end) state_nxt = S_PLACE;
        else if (pidx == pref_r) state_nxt = S_POLL_SEL;
        else if (cur_cnt == '0) state_nxt = S_PLACE;
        else state_nxt = S_POLL_HEAD;
      end
      S_POLL_HEAD: state_nxt = S_POLL_SUB;
      S_POLL_SUB:  state_nxt = S_POLL_RD;
      S_POLL_RD: begin
        if (kcnt_r != cur_cnt) state_nxt = S_POLL_ACC;
        else if (cmp_lt) state_nxt = S_PLACE;
        else state_nxt = S_POLL_SEL;
      end
      S_POLL_ACC:  state_nxt = S_POLL_RD;
      S_PLACE:     state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tag_nxt    = tag_r;
    arr_nxt    = arr_r;
    burst_nxt  = burst_r;
    pref_nxt   = pref_r;
    proc_nxt   = proc_r;
    acc_nxt    = acc_r;
    kcnt_nxt   = kcnt_r;
    slot_nxt   = slot_r;
    start_nxt  = start_r;
    status_nxt = status_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    mem_raddr  = AW'(proc_base + AW'(slot_r));
    mem_waddr  = AW'(proc_base + AW'(tail_slot));
    mem_wdata  = {burst_r, start_r};
    mem_we     = 1'b0;

    res_valid_nxt  = res_valid_r && out_stall;
    res_tag_nxt    = res_tag_r;
    res_proc_nxt   = res_proc_r;
    res_start_nxt  = res_start_r;
    res_end_nxt    = res_end_r;
    res_redir_nxt  = res_redir_r;
    res_status_nxt = res_status_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tag_nxt   = in_job_tag;
          arr_nxt   = in_arrival_time;
          burst_nxt = in_burst_time;
          pref_nxt  = pref_reduce(in_preferred_processor);
          proc_nxt  = '0;
        end
      end
      S_DROP_SEL: begin
        mem_raddr = AW'(proc_base + AW'(cur_head));
        if (proc_end) proc_nxt = PCW'(pref_r);
        else if (cur_cnt == '0) proc_nxt = proc_r + 1'b1;
      end
      S_DROP_CHK: begin
        if (cmp_lt) begin
          head_nxt[pidx]  = head_inc;
          count_nxt[pidx] = cur_cnt - 1'b1;
        end else begin
          proc_nxt = proc_r + 1'b1;
        end
      end
      S_LOAD_INIT: begin
        acc_nxt  = '0;
        kcnt_nxt = '0;
        slot_nxt = cur_head;
      end
      S_LOAD_RD: begin
        if (kcnt_r == cur_cnt && !cmp_lt) proc_nxt = '0;
      end
      S_LOAD_ACC, S_POLL_ACC: begin
        acc_nxt  = add_s;
        kcnt_nxt = kcnt_r + 1'b1;
        slot_nxt = slot_inc;
      end
      S_POLL_SEL: begin
        mem_raddr = AW'(proc_base + AW'(cur_head));
        if (proc_end) begin
          proc_nxt = PCW'(pref_r);
        end else if (pidx == pref_r) begin
          proc_nxt = proc_r + 1'b1;
        end else if (cur_cnt != '0) begin
          slot_nxt = head_inc;
          kcnt_nxt = CW'(1);
        end
      end
      S_POLL_HEAD: begin
        acc_nxt = ACC_W'(sum_sat);
      end
      S_POLL_SUB: begin
        acc_nxt = cmp_lt ? '0 : add_s;
      end
      S_POLL_RD: begin
        if (kcnt_r == cur_cnt && !cmp_lt) proc_nxt = proc_r + 1'b1;
      end
      S_PLACE: begin
        status_nxt = (cur_cnt >= CW'(QUEUE_DEPTH)) ? STATUS_REJECTED : STATUS_QUEUED;
        start_nxt  = cmp_lt ? cur_last : arr_r;
      end
      S_COMMIT: begin
        if (out_free) begin
          if (status_r == STATUS_QUEUED) begin
            mem_we          = 1'b1;
            count_nxt[pidx] = cur_cnt + 1'b1;
            last_nxt[pidx]  = sum_sat;
          end
          res_valid_nxt  = 1'b1;
          res_tag_nxt    = tag_r;
          res_proc_nxt   = PROC_W'(pidx);
          res_start_nxt  = (status_r == STATUS_QUEUED) ? start_r : '0;
          res_end_nxt    = (status_r == STATUS_QUEUED) ? sum_sat : '0;
          res_redir_nxt  = (pidx != pref_r);
          res_status_nxt = status_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PROC; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
        last_r[i]  <= '0;
      end
      for (int i = 0; i < NUM_THR; i++) begin
        thr_r[i] <= THR_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      if (cfg_valid && cfg_ready) thr_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    tag_r        <= tag_nxt;
    arr_r        <= arr_nxt;
    burst_r      <= burst_nxt;
    pref_r       <= pref_nxt;
    proc_r       <= proc_nxt;
    acc_r        <= acc_nxt;
    kcnt_r       <= kcnt_nxt;
    slot_r       <= slot_nxt;
    start_r      <= start_nxt;
    status_r     <= status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_proc_r   <= res_proc_nxt;
    res_start_r  <= res_start_nxt;
    res_end_r    <= res_end_nxt;
    res_redir_r  <= res_redir_nxt;
    res_status_r <= res_status_nxt;
  end

  // job store
  always_ff @(posedge clk) begin
    if (mem_we) job_mem[mem_waddr] <= mem_wdata;
    mem_q <= job_mem[mem_raddr];
  end

endmodule

FILE: hdl/sild_checker.sv
// port-level checks for the load dispatcher and their bind
module sild_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sild_pkg::TAG_W-1:0]    out_result_tag,
  input logic [sild_pkg::PROC_W-1:0]   out_assigned_processor,
  input logic [sild_pkg::TIME_W-1:0]   out_start_time,
  input logic [sild_pkg::TIME_W-1:0]   out_end_time,
  input logic                          out_redirected,
  input logic                          out_status
);
  import sild_pkg::*;

  // a stalled result beat holds its tag, processor and end time
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_tag)
      && $stable(out_assigned_processor) && $stable(out_end_time))
  else $error("stalled result beat changed");

  // a rejected job reports zero times
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_REJECTED |-> out_start_time == '0 && out_end_time == '0)
  else $error("rejected job carries times");

  // a queued job never ends before it starts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_QUEUED |-> out_end_time >= out_start_time)
  else $error("end time below start time");

  // an accepted beat keeps the input side busy
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
  else $error("input taken again too early");

endmodule

bind sender_initiated_load_dispatcher sild_port_checks u_sild_port_checks (.*);
